/* hdl/sample_log_min_max_mean_macros.svh */
// Assertion macros used by the checker file of the sample statistics block.
`ifndef SAMPLE_LOG_MIN_MAX_MEAN_MACROS_SVH
`define SAMPLE_LOG_MIN_MAX_MEAN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/slmm_pkg.sv */
// Package with widths, word types, state codes and helpers of the sample statistics block.
`default_nettype none
package slmm_pkg;

    localparam int DEPTH      = 128;
    localparam int RAW_W      = 10;
    localparam int VAL_W      = 8;
    localparam int VAL_MAX    = 254;
    localparam int CNT_W      = $clog2(DEPTH);
    localparam int SUM_W      = $clog2(VAL_MAX * (DEPTH - 1) + 1);
    localparam int MEAN_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int CUR_W      = 11;
    localparam int ENTRY_W    = 7;
    localparam int STEP_W     = $clog2(MEAN_W);
    localparam int RAW_OFFSET = 4;

    localparam logic FUNC_LOG   = 1'b0;
    localparam logic FUNC_STATS = 1'b1;

    typedef struct packed {
        logic             func;
        logic [RAW_W-1:0] raw_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [CUR_W-1:0]   current_quarters;
        logic        [MEAN_W-1:0]  mean_x256;
        logic        [VAL_W-1:0]   max_value;
        logic        [VAL_W-1:0]   min_value;
        logic        [ENTRY_W-1:0] entry_count;
        logic                      window_empty;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic out_busy;
    } t_dp_stat;

    // Readings below the offset clamp to zero instead of going negative.
    function automatic logic [VAL_W-1:0] scale_sample(input logic [RAW_W-1:0] raw);
        logic [RAW_W-1:0] diff;
        diff = raw - RAW_W'(RAW_OFFSET);
        if (raw < RAW_W'(RAW_OFFSET)) begin
            return '0;
        end
        return VAL_W'(diff >> 2);
    endfunction

endpackage
`default_nettype wire

/* hdl/slmm_if.sv */
// Valid/ready stream interfaces for the sample and statistics channels.
`default_nettype none
interface slmm_in_if
    import slmm_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface slmm_out_if
    import slmm_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/slmm_ctrl.sv */
// Controller state machine: accepts a word, sequences the mean divider, hands off the result.
`default_nettype none
module slmm_ctrl
    import slmm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output t_dp_cmd       o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                // No word is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                // An empty window has a mean of zero, so the divider is skipped.
                n_state    = i_stat.empty ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_W'(MEAN_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/slmm_dp.sv */
// Datapath: running aggregates, restoring divider for the mean, and output register.
`default_nettype none
module slmm_dp
    import slmm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    input  wire t_in_word i_in_data,
    input  wire logic     i_out_ready,
    output t_dp_stat      o_stat,
    output logic          o_out_valid,
    output t_out_word     o_out_data
);

    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [VAL_W-1:0]  r_max, n_max;
    logic [VAL_W-1:0]  r_min, n_min;
    logic [RAW_W-1:0]  r_raw;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [MEAN_W-1:0] r_quo, n_quo;
    logic              r_out_valid;
    t_out_word         r_out;

    logic [VAL_W-1:0] val;
    logic [CNT_W:0]   count_inc;
    logic [CNT_W:0]   trial;
    logic             fits;

    assign val       = scale_sample(i_in_data.raw_sample);
    assign count_inc = {1'b0, r_count} + 1'b1;

    // Aggregate update when a sample is logged; the window restarts once full.
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_max   = r_max;
        n_min   = r_min;
        if (i_cmd.accept && (i_in_data.func == FUNC_LOG)) begin
            if (count_inc >= (CNT_W + 1)'(DEPTH)) begin
                n_count = '0;
                n_sum   = '0;
                n_max   = '0;
                n_min   = '0;
            end else begin
                n_count = count_inc[CNT_W-1:0];
                n_sum   = r_sum + SUM_W'(val);
                if (r_count == '0) begin
                    n_max = val;
                    n_min = val;
                end else begin
                    if (val > r_max) n_max = val;
                    if (val < r_min) n_min = val;
                end
            end
        end
    end

    // The quotient never exceeds sixteen bits, so the high dividend bits
    // already form a partial remainder below the divisor.
    assign trial = {r_rem, r_quo[MEAN_W-1]};
    assign fits  = trial >= {1'b0, r_count};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_cmd.load) begin
            n_rem = CNT_W'(r_sum >> FRAC_W);
            n_quo = {r_sum[FRAC_W-1:0], {(MEAN_W - FRAC_W){1'b0}}};
        end else if (i_cmd.step) begin
            n_rem = fits ? CNT_W'(trial - {1'b0, r_count}) : trial[CNT_W-1:0];
            n_quo = {r_quo[MEAN_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_max   <= n_max;
            r_min   <= n_min;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_cmd.accept) begin
            r_raw <= i_in_data.raw_sample;
        end
        if (i_cmd.finish) begin
            r_out.current_quarters <= $signed(CUR_W'(r_raw) - CUR_W'(RAW_OFFSET));
            r_out.mean_x256        <= (r_count == '0) ? '0 : r_quo;
            r_out.max_value        <= r_max;
            r_out.min_value        <= r_min;
            r_out.entry_count      <= ENTRY_W'(r_count);
            r_out.window_empty     <= (r_count == '0);
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule
`default_nettype wire

/* hdl/sample_log_min_max_mean.sv */
// Top level of the sample statistics block: controller plus datapath.
//
// Input channel i_sample carries one word per sample: func selects logging
// (FUNC_LOG) or a statistics request (FUNC_STATS), raw_sample is the 10-bit
// converter reading. Output channel o_stats returns exactly one word per
// accepted input: current reading in quarter units, Q8.8 mean, maximum,
// minimum and entry count of the window, and an empty flag.
// Statistics on a log word already include the sample just logged, unless
// it fills the window, which then restarts empty without that sample.
// Aggregates update at the accepting edge; then the divider is loaded, runs
// its steps and the result is handed off (an empty window skips the steps).
// A new word is accepted only back in idle, after the hand-off; the mean
// comes from a restoring divider that yields one quotient bit per cycle.
// The output register lets a new word be accepted while a result waits;
// if the receiver stalls longer, the next result holds in the controller
// until the output register frees, and no further word is accepted.
// Synchronous active-low reset empties the window and drops the output valid.
`default_nettype none
module sample_log_min_max_mean
    import slmm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    slmm_in_if.sink   i_sample,
    slmm_out_if.source o_stats
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;
    t_out_word out_data;

    slmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    slmm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_sample.data),
        .i_out_ready (o_stats.ready),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .o_out_data  (out_data)
    );

    assign i_sample.ready = in_ready;
    assign o_stats.valid  = out_valid;
    assign o_stats.data   = out_data;

endmodule
`default_nettype wire

/* hdl/slmm_checker.sv */
// Port-level checker for the sample statistics block and its bind to the top level.
`default_nettype none
`include "sample_log_min_max_mean_macros.svh"
module slmm_checker
    import slmm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word i_out_data
);

    `SLMM_ASSERT_NOW(a_empty_flag, i_out_valid, i_out_data.window_empty == (i_out_data.entry_count == '0), "empty flag disagrees with entry count")
    `SLMM_ASSERT_NOW(a_empty_zero, i_out_valid && i_out_data.window_empty, (i_out_data.mean_x256 == '0) && (i_out_data.max_value == '0) && (i_out_data.min_value == '0), "empty window reports nonzero statistics")
    `SLMM_ASSERT_NOW(a_min_le_max, i_out_valid && !i_out_data.window_empty, i_out_data.min_value <= i_out_data.max_value, "minimum above maximum")
    `SLMM_ASSERT_NOW(a_mean_bounds, i_out_valid && !i_out_data.window_empty, (i_out_data.mean_x256 >= {i_out_data.min_value, 8'h00}) && (i_out_data.mean_x256 <= {i_out_data.max_value, 8'h00}), "mean outside min/max range")
    `SLMM_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result word changed")

endmodule

bind sample_log_min_max_mean slmm_checker u_slmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_stats.valid),
    .i_out_ready (o_stats.ready),
    .i_out_data  (o_stats.data)
);
`default_nettype wire
